### hdl/dqdel_pkg.sv
package dqdel_pkg;

	localparam int DEPTH       = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = ((OP_W + DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + ST_W + CNT_W + 7) / 8) * 8;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_DELETE     = 3'd4,
		OP_COUNT      = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	// Commands broadcast to every cell of the chain for one cycle.
	typedef struct packed {
		logic push_back;
		logic push_front;
		logic pop_front;
		logic del;
	} cell_cmd_t;

endpackage

### hdl/dqdel_cell.sv
module dqdel_cell
	import dqdel_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  word_t     word,
	input  logic      occ,
	input  logic      prev_occ,
	input  word_t     prev_data,
	input  word_t     next_data,
	input  logic      hit_in,
	output logic      hit_out,
	output word_t     data
);

	word_t data_q;
	word_t data_d;
	logic  match;

	// Match only an occupied slot; the earliest match wins down the chain.
	assign match   = occ && (data_q == word);
	assign hit_out = hit_in || match;
	assign data    = data_q;

	always_comb begin
		data_d = data_q;
		if (cmd.push_front) begin
			data_d = prev_data;
		end else if (cmd.push_back && !occ && prev_occ) begin
			data_d = word;
		end else if (cmd.pop_front || (cmd.del && (hit_in || match))) begin
			data_d = next_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### hdl/double_ended_queue_with_delete.sv
// Bounded double-ended queue of DEPTH signed words with delete-by-value. Each
// input transfer carries one operation (push back, push front, pop back, pop
// front, delete first match counted from the front, or count; codes six and
// seven act as count) and yields exactly one output transfer with the word
// read, a status and the occupancy after the operation. Storage is a row of
// cells, slot 0 at the front; every cell takes a word from its left or right
// neighbor in the same cycle, so each operation, delete included, is done at
// once: one operation per cycle is taken unless the output stalls, and its
// result appears in the cycle after acceptance. The delete path sets the clock
// limit: all cells compare against the value in parallel and the first-match
// flag ripples through the DEPTH cells. A pop of an empty queue returns -1 with
// status empty; a push into a full queue is dropped with status full; a delete
// that finds nothing leaves the queue alone with status no-match. Stored words
// are not cleared by reset; only slots below the occupancy are ever read.
module double_ended_queue_with_delete
	import dqdel_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// operation [2:0], value [34:3], zero pad above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_value [31:0], status [33:32], occupancy [38:34], zero pad above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef struct packed {
		logic [CNT_W-1:0] occupancy;
		status_t          status;
		word_t            read_value;
	} result_t;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             out_valid_q;
	result_t          out_res_q;
	result_t          res_d;

	op_t       op;
	word_t     word;
	logic      accept;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;
	cell_cmd_t cell_cmd;
	word_t     rd_back;

	word_t     cell_data [DEPTH];
	logic      occ       [DEPTH+1];
	logic      hit       [DEPTH+1];

	// Unpack the request.
	assign op   = op_t'(s_axis_tdata[OP_W-1:0]);
	assign word = s_axis_tdata[OP_W+DATA_WIDTH-1:OP_W];

	// Take a new transfer whenever the result register is free or drains now.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Thermometer of occupied slots, plus a never-occupied slot past the end.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (CNT_W'(i) < count_q);
		end
		occ[DEPTH] = 1'b0;
	end

	// Select the back entry: the last occupied slot.
	always_comb begin
		rd_back = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (occ[i] && !occ[i+1]) begin
				rd_back = rd_back | cell_data[i];
			end
		end
	end

	assign hit[0] = 1'b0;

	// Cell chain: push front shifts toward the back, pop front and delete
	// shift toward the front; the first cell is fed the pushed word.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t prev_w;
		word_t next_w;
		logic  prev_o;

		if (g == 0) begin : g_first
			assign prev_w = word;
			assign prev_o = 1'b1;
		end else begin : g_mid
			assign prev_w = cell_data[g-1];
			assign prev_o = occ[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_w = cell_data[g];
		end else begin : g_inner
			assign next_w = cell_data[g+1];
		end

		dqdel_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd),
			.word      (word),
			.occ       (occ[g]),
			.prev_occ  (prev_o),
			.prev_data (prev_w),
			.next_data (next_w),
			.hit_in    (hit[g]),
			.hit_out   (hit[g+1]),
			.data      (cell_data[g])
		);
	end

	// Decode the operation into cell commands, the next count and the result.
	always_comb begin
		cmd              = '0;
		count_d          = count_q;
		res_d.read_value = '0;
		res_d.status     = ST_OK;
		unique case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else begin
					cmd.push_back = 1'b1;
					count_d       = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else begin
					cmd.push_front = 1'b1;
					count_d        = count_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					res_d.read_value = '1;
					res_d.status     = ST_EMPTY;
				end else begin
					res_d.read_value = rd_back;
					count_d          = count_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					res_d.read_value = '1;
					res_d.status     = ST_EMPTY;
				end else begin
					res_d.read_value = cell_data[0];
					cmd.pop_front    = 1'b1;
					count_d          = count_q - CNT_W'(1);
				end
			end
			OP_DELETE: begin
				// With no match no cell sees a hit, so the chain holds.
				cmd.del = 1'b1;
				if (hit[DEPTH]) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					res_d.status = ST_NOMATCH;
				end
			end
			default: begin
				// count and unused codes: report only
			end
		endcase
		res_d.occupancy = count_d;
	end

	// Move the chain only on an accepted transfer.
	assign cell_cmd = accept ? cmd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_res_q);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && !full
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push into non-full queue did not add an entry");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_POP_BACK || op == OP_POP_FRONT) && empty
		|=> m_axis_tvalid && out_res_q.status == ST_EMPTY && out_res_q.read_value == '1)
		else $error("pop of empty queue not reported");

	a_occ_reported: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_res_q.occupancy == count_q)
		else $error("reported occupancy differs from count");
`endif

endmodule
